// ===== sv/tcps_pkg.sv =====
// Shared constants, types and helper functions for the tick counter priority scheduler.
package tcps_pkg;

  // Task table sizing: the task index is two bits, task 0 is the idle task.
  localparam int TASK_COUNT   = 4;
  localparam int MAX_PRIORITY = 15;
  localparam int TASK_SLOTS   = 4;
  localparam int ACTIVE_TASKS = (TASK_COUNT < TASK_SLOTS) ? TASK_COUNT : TASK_SLOTS;

  localparam int TASK_W  = 2;
  localparam int SLICE_W = 4;
  localparam int PRIO_W  = 4;
  localparam int CFG_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam int PRIO_REGS = 3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_PRIO_ONE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRIO_TWO   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PRIO_THREE = 2'd2;

  localparam logic [TASK_W-1:0] IDLE_TASK = '0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the new item and snapshot the running task
    logic dec;       // decrement the running task's counter
    logic pick;      // switch to the task with the largest counter
    logic fill;      // reload every active counter from its priority
    logic load_out;  // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick;          // captured tick bit
    logic need_resched;  // running task is idle or its counter is already zero
    logic dec_to_zero;   // running task's counter is one, a decrement empties it
    logic none_ready;    // every active counter is zero
  } dp_sts_t;

  // Reload value of a priority register: zero acts as one, clamp at the limit.
  function automatic logic [SLICE_W-1:0] reload_value(input logic [PRIO_W-1:0] prio);
    logic [SLICE_W-1:0] val;
    val = prio;
    if (val == '0) begin
      val = SLICE_W'(1);
    end
    if (32'(val) > MAX_PRIORITY) begin
      val = SLICE_W'(MAX_PRIORITY);
    end
    return val;
  endfunction

endpackage

// ===== sv/tcps_ctrl.sv =====
// Controller state machine of the tick counter priority scheduler.
module tcps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  tcps_pkg::dp_sts_t sts,
  output tcps_pkg::dp_cmd_t cmd
);
  import tcps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!sts.tick) begin
          state_nxt = ST_OUT;
        end else if (sts.need_resched) begin
          state_nxt = ST_PICK;
        end else begin
          cmd.dec   = 1'b1;
          state_nxt = sts.dec_to_zero ? ST_PICK : ST_OUT;
        end
      end
      ST_PICK: begin
        // With nothing left to run, reload first and pick again.
        if (sts.none_ready) begin
          state_nxt = ST_FILL;
        end else begin
          cmd.pick  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/tcps_dp.sv =====
// Datapath of the tick counter priority scheduler: registers, counters and task pick.
module tcps_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcps_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tcps_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_tick,
  input  tcps_pkg::dp_cmd_t               cmd,
  output tcps_pkg::dp_sts_t               sts,
  output logic [tcps_pkg::TASK_W-1:0]     out_running_task,
  output logic                            out_switched,
  output logic                            out_refilled,
  output logic [tcps_pkg::SLICE_W-1:0]    out_remaining_slice
);
  import tcps_pkg::*;

  logic [PRIO_W-1:0]  prio_r   [PRIO_REGS];
  logic [PRIO_W-1:0]  prio_nxt [PRIO_REGS];
  logic [SLICE_W-1:0] cnt_r    [TASK_SLOTS];
  logic [SLICE_W-1:0] cnt_nxt  [TASK_SLOTS];
  logic [TASK_W-1:0]  cur_r, cur_nxt;
  logic [TASK_W-1:0]  prev_r, prev_nxt;
  logic               tick_r, tick_nxt;
  logic               refill_r, refill_nxt;

  logic [TASK_W-1:0]  out_task_r, out_task_nxt;
  logic               out_sw_r, out_sw_nxt;
  logic               out_rf_r, out_rf_nxt;
  logic [SLICE_W-1:0] out_slice_r, out_slice_nxt;

  logic [TASK_W-1:0]  best_task;
  logic [SLICE_W-1:0] best_val;
  logic [SLICE_W-1:0] cur_cnt;

  assign cur_cnt = cnt_r[cur_r];

  // Largest counter among the active tasks; strict compare keeps the lowest index on ties.
  always_comb begin
    best_task = IDLE_TASK;
    best_val  = '0;
    for (int t = 1; t < TASK_SLOTS; t++) begin
      if (t < ACTIVE_TASKS && cnt_r[t] > best_val) begin
        best_val  = cnt_r[t];
        best_task = TASK_W'(t);
      end
    end
  end

  assign sts.tick         = tick_r;
  assign sts.need_resched = (cur_r == IDLE_TASK) || (cur_cnt == '0);
  assign sts.dec_to_zero  = (cur_cnt == SLICE_W'(1));
  assign sts.none_ready   = (best_task == IDLE_TASK);

  always_comb begin
    prio_nxt = prio_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PRIO_ONE:   prio_nxt[0] = cfg_data;
        REG_PRIO_TWO:   prio_nxt[1] = cfg_data;
        REG_PRIO_THREE: prio_nxt[2] = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    tick_nxt   = tick_r;
    refill_nxt = refill_r;
    if (cmd.capture) begin
      tick_nxt   = in_tick;
      prev_nxt   = cur_r;
      refill_nxt = 1'b0;
    end
    if (cmd.dec) begin
      cnt_nxt[cur_r] = cur_cnt - SLICE_W'(1);
    end
    if (cmd.pick) begin
      cur_nxt = best_task;
    end
    if (cmd.fill) begin
      for (int t = 1; t < TASK_SLOTS; t++) begin
        if (t < ACTIVE_TASKS) begin
          cnt_nxt[t] = reload_value(prio_r[t-1]);
        end
      end
      refill_nxt = 1'b1;
    end
  end

  always_comb begin
    out_task_nxt  = out_task_r;
    out_sw_nxt    = out_sw_r;
    out_rf_nxt    = out_rf_r;
    out_slice_nxt = out_slice_r;
    if (cmd.load_out) begin
      out_task_nxt  = cur_r;
      out_sw_nxt    = (cur_r != prev_r);
      out_rf_nxt    = refill_r;
      out_slice_nxt = (cur_r == IDLE_TASK) ? '0 : cur_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PRIO_REGS; i++) begin
        prio_r[i] <= PRIO_W'(1);
      end
      for (int i = 0; i < TASK_SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
      cur_r    <= IDLE_TASK;
      prev_r   <= IDLE_TASK;
      tick_r   <= 1'b0;
      refill_r <= 1'b0;
    end else begin
      prio_r   <= prio_nxt;
      cnt_r    <= cnt_nxt;
      cur_r    <= cur_nxt;
      prev_r   <= prev_nxt;
      tick_r   <= tick_nxt;
      refill_r <= refill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_task_r  <= out_task_nxt;
    out_sw_r    <= out_sw_nxt;
    out_rf_r    <= out_rf_nxt;
    out_slice_r <= out_slice_nxt;
  end

  assign out_running_task    = out_task_r;
  assign out_switched        = out_sw_r;
  assign out_refilled        = out_rf_r;
  assign out_remaining_slice = out_slice_r;

endmodule

// ===== sv/tick_counter_priority_scheduler.sv =====
// Top level of the tick counter priority scheduler: controller plus datapath.
//
// Each input item is one timer event on in_tick. For every accepted item the
// block returns exactly one result item: the task running after the event,
// whether it changed, whether all time slices were reloaded, and the running
// task's remaining slice (zero for the idle task). Both channels use valid and
// stall; an item moves at a rising edge with valid high and stall low.
// The block works on one item at a time. After the accepting edge the
// controller runs a decide step, then goes straight to the output step
// when the event needs no new pick (no tick, or a decrement that leaves the
// slice nonzero), through a pick step first with a pick, and through a pick
// check, a reload step and a pick when the table must be reloaded. The result
// shows on out_valid in the cycle after the output step, as in_stall drops.
// The result sits in an output register, so the block takes the next item
// while the previous result waits; if the receiver still stalls when the next
// result is ready, the block holds in its final step until the register frees.
// Synchronous active-low reset clears all slice counters, selects the idle
// task, sets every priority register to one and drops out_valid. The user must
// write priorities (cfg_we, cfg_index, cfg_data) only while idle; unchecked here.
module tick_counter_priority_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcps_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tcps_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcps_pkg::TASK_W-1:0]     out_running_task,
  output logic                            out_switched,
  output logic                            out_refilled,
  output logic [tcps_pkg::SLICE_W-1:0]    out_remaining_slice
);
  import tcps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: accept, decide, optional pick and reload, then load the result.
  tcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Priority registers, slice counters, running task and the result register.
  tcps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_tick             (in_tick),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_running_task    (out_running_task),
    .out_switched        (out_switched),
    .out_refilled        (out_refilled),
    .out_remaining_slice (out_remaining_slice)
  );

endmodule

// ===== sim/tb_tick_counter_priority_scheduler.sv =====
// Self-checking testbench for the tick counter priority scheduler.
module tb_tick_counter_priority_scheduler;
  import tcps_pkg::*;

  // One result item of the scheduler, split into its fields.
  typedef struct packed {
    logic [TASK_W-1:0]  runner;
    logic               switched;
    logic               refilled;
    logic [SLICE_W-1:0] remain;
  } sched_result_t;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 166;
  localparam int MAX_SENDER_GAP  = 30;

  // The scoreboard keeps its own copy of the slice table, the running task
  // and the priority registers. Every accepted tick is played against that
  // copy right away, and the expected result is queued until the block
  // hands back its result item.
  class tick_schedule_board;
    logic [PRIO_W-1:0]  prio_regs[PRIO_REGS];
    logic [SLICE_W-1:0] slice_left[TASK_SLOTS];
    logic [TASK_W-1:0]  running;
    sched_result_t      expected_picks[$];
    int                 mismatches;

    function void clear();
      foreach (prio_regs[i]) prio_regs[i] = PRIO_W'(1);
      foreach (slice_left[i]) slice_left[i] = '0;
      running = IDLE_TASK;
      expected_picks.delete();
      mismatches = 0;
    endfunction

    function void set_priority(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (int'(idx) < PRIO_REGS) begin
        prio_regs[idx] = val;
      end
    endfunction

    // A zero priority still gives one tick of run time; large ones clamp.
    function logic [SLICE_W-1:0] refill_level(int t);
      logic [SLICE_W-1:0] lvl;
      lvl = prio_regs[t-1];
      if (lvl == '0) begin
        lvl = SLICE_W'(1);
      end
      if (int'(lvl) > MAX_PRIORITY) begin
        lvl = SLICE_W'(MAX_PRIORITY);
      end
      return lvl;
    endfunction

    // Largest remaining slice wins; the strict compare keeps the lowest index.
    function logic [TASK_W-1:0] fullest_task();
      logic [TASK_W-1:0]  best;
      logic [SLICE_W-1:0] best_left;
      best = IDLE_TASK;
      best_left = '0;
      for (int t = 1; t < ACTIVE_TASKS; t++) begin
        if (slice_left[t] > best_left) begin
          best_left = slice_left[t];
          best = TASK_W'(t);
        end
      end
      return best;
    endfunction

    function void note_tick(logic tick);
      logic [TASK_W-1:0] prev;
      logic              resched;
      sched_result_t     exp;
      prev = running;
      resched = 1'b0;
      exp.refilled = 1'b0;
      if (tick) begin
        if (running == IDLE_TASK || slice_left[running] == '0) begin
          resched = 1'b1;
        end else begin
          slice_left[running] = slice_left[running] - SLICE_W'(1);
          resched = (slice_left[running] == '0);
        end
        if (resched) begin
          running = fullest_task();
          if (running == IDLE_TASK) begin
            for (int t = 1; t < ACTIVE_TASKS; t++) begin
              slice_left[t] = refill_level(t);
            end
            exp.refilled = 1'b1;
            running = fullest_task();
          end
        end
      end
      exp.runner = running;
      exp.switched = (running != prev);
      exp.remain = (running == IDLE_TASK) ? '0 : slice_left[running];
      expected_picks.push_back(exp);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result with no tick pending: task %0d sw %0b rf %0b slice %0d",
                   got.runner, got.switched, got.refilled, got.remain);
        end
        return;
      end
      exp = expected_picks.pop_front();
      if (got.runner !== exp.runner || got.switched !== exp.switched ||
          got.refilled !== exp.refilled || got.remain !== exp.remain) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("ERROR: expected task %0d sw %0b rf %0b slice %0d,",
                 exp.runner, exp.switched, exp.refilled, exp.remain);
          $display(" got task %0d sw %0b rf %0b slice %0d",
                   got.runner, got.switched, got.refilled, got.remain);
        end
      end
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_tick = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TASK_W-1:0] out_running_task;
  logic out_switched;
  logic out_refilled;
  logic [SLICE_W-1:0] out_remaining_slice;

  // Idle rates in percent per cycle, changed from phase to phase.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  tick_schedule_board book = new();

  tick_counter_priority_scheduler dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_tick(in_tick),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_running_task(out_running_task),
    .out_switched(out_switched),
    .out_refilled(out_refilled),
    .out_remaining_slice(out_remaining_slice)
  );

  always #5 clk = ~clk;

  // The receiver decides at each falling edge whether to hold off the next
  // result, so the stall is stable well before the edge that samples it.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // A result item moves at a rising edge with out_valid high and out_stall
  // low; the values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_result(sched_result_t'{out_running_task, out_switched,
                                        out_refilled, out_remaining_slice});
    end
  end

  // Hold the sender back until every queued result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() > 0) begin
      @(negedge clk);
    end
  endtask

  // Offer one tick item after a random gap, then wait for the accepting edge.
  // The item is booked only once the handshake completes.
  task automatic send_tick(logic tick);
    int gap;
    gap = 0;
    while (gap < MAX_SENDER_GAP && $urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= tick;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    book.note_tick(tick);
  endtask

  task automatic write_priority(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.set_priority(idx, val);
  endtask

  // Priorities change only once the block has handed back everything. Each
  // load also pokes the unused index, which the block has to ignore.
  task automatic load_priorities(logic [CFG_W-1:0] p1, logic [CFG_W-1:0] p2,
                                 logic [CFG_W-1:0] p3);
    drain_results();
    write_priority(REG_PRIO_ONE, p1);
    write_priority(REG_PRIO_TWO, p2);
    write_priority(REG_PRIO_THREE, p3);
    write_priority(REG_UNUSED, CFG_W'($urandom_range(15)));
  endtask

  initial begin
    book.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset priorities of one. A no-tick item on the idle
    // task comes first, then the first tick refills the table from idle and
    // the three-way tie has to go to task one. Further ticks walk the
    // round of single-tick slices into the next refill.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (4) send_tick(1'b1);

    // A zero priority must reload as one, and the two top priorities tie
    // at the largest value. The run goes through a refill, with a
    // no-tick item in the middle of a slice.
    load_priorities(4'd0, 4'd15, 4'd15);
    repeat (12) send_tick(1'b1);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);

    // Random part. Each phase sets priorities and an idling pattern: no
    // idling, a slow sender, a slow receiver, then both. Ticks dominate
    // so the slices keep draining and refilling; now and then the sender
    // waits for the block to run dry.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: load_priorities(4'd15, 4'd15, 4'd15);
        1: load_priorities(4'd1, 4'd1, 4'd1);
        2: load_priorities(4'd0, 4'd15, 4'd0);
        3: load_priorities(4'd0, 4'd0, 4'd0);
        default: load_priorities(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
                                 CFG_W'($urandom_range(15)));
      endcase
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 54;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 54;
        end
        default: begin
          sender_idle_pct = 32;
          receiver_stall_pct = 32;
        end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(49) == 0) begin
          drain_results();
        end
        send_tick($urandom_range(99) < 85);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("tb_tick_counter_priority_scheduler: PASS");
    end else begin
      $display("tb_tick_counter_priority_scheduler: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of all items.
  initial begin
    #5000000;
    $display("tb_tick_counter_priority_scheduler: FAIL");
    $finish;
  end

endmodule
